/* rtl/stack_with_value_deletion_macros.svh */
// Assertion helpers for the stack sequencer (swvd_seq).
// Both expect clk and rst_n in scope.
`ifndef STACK_WITH_VALUE_DELETION_MACROS_SVH
`define STACK_WITH_VALUE_DELETION_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define SWVD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SWVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/swvd_pkg.sv */
package swvd_pkg;

  // Address field width of the storage request; covers the largest stack
  localparam int MEM_AW = 8;

  typedef enum logic [1:0] {
    CMD_PUSH      = 2'd0,
    CMD_POP       = 2'd1,
    CMD_DEL_FIRST = 2'd2,
    CMD_DEL_ALL   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [31:0]       wdata;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] top_value;
    logic [3:0]         entry_count;
    logic               is_empty;
    logic               is_full;
    logic [3:0]         removed_count;
    status_t            status;
  } result_t;

endpackage

/* rtl/stack_with_value_deletion.sv */
// Bounded stack of signed 32-bit values, DEPTH entries deep (index 0 is the bottom). Each input
// transaction carries a command in in_tuser and a value in in_tdata: push, pop, delete the first
// entry equal to the value counted from the bottom, or delete every equal entry; deletion closes
// the gaps and keeps the survivors in order. Every command yields exactly one result transaction
// with the new top (0 when empty), the entry count, empty and full flags, the number of entries
// removed and a status (push dropped when full, pop on empty). A pop that leaves entries behind
// first fetches the entry below the old top in a wait state (POPWT); a deletion walks the stored
// entries with one comparator, one per cycle through the single registered read of the entry
// store, writing each survivor back into the lowest free slot. The next command is accepted
// once the result has moved into the output register, so it may overlap a result still waiting
// on out_tready. No clearing pass is needed after reset: only entries below the fill level are
// ever read.
module stack_with_value_deletion
  import swvd_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] top_value, [35:32] entry_count, [36] is_empty, [37] is_full,
  // [41:38] removed_count, [43:42] status, [47:44] zero
  output logic [47:0] out_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic               seq_ready;
  logic               start;
  logic               out_free;
  mem_req_t           mem_req;
  result_t            res;
  logic signed [31:0] mem_q_r;
  logic [31:0]        mem [DEPTH];
  logic               out_tvalid_r;
  logic [47:0]        out_tdata_r;

  // accept a command only while the sequencer sits idle
  assign in_tready = seq_ready;
  assign start     = in_tvalid && seq_ready;
  // the output register is free when empty or being drained this cycle
  assign out_free  = !out_tvalid_r || out_tready;

  swvd_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_cmd   (in_tuser),
    .in_value (in_tdata),
    .out_free (out_free),
    .mem_q    (mem_q_r),
    .ready    (seq_ready),
    .mem_req  (mem_req),
    .res      (res)
  );

  // Entry store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
    end
    mem_q_r <= mem[mem_req.raddr[AW-1:0]];
  end

  // Output register: load a finished result when the slot is free, hold it otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_free) begin
      out_tvalid_r <= res.valid;
    end
    if (out_free && res.valid) begin
      out_tdata_r <= {4'b0000, res.status, res.removed_count, res.is_full, res.is_empty,
                      res.entry_count, res.top_value};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* rtl/swvd_seq.sv */
module swvd_seq
  import swvd_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_value,
  input  logic               out_free,
  input  logic signed [31:0] mem_q,
  output logic               ready,
  output mem_req_t           mem_req,
  output result_t            res
);

  `include "stack_with_value_deletion_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    POPWT,
    FINISH
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      rd_r, rd_nxt;
  logic [CW-1:0]      wr_r, wr_nxt;
  logic [CW-1:0]      removed_r, removed_nxt;
  logic               dv_r, dv_nxt;
  logic               first_r, first_nxt;
  logic signed [31:0] top_r, top_nxt;
  logic signed [31:0] match_r, match_nxt;
  status_t            status_r, status_nxt;
  logic               hit;

  // Shared comparator: one stored entry against the match value per cycle
  assign hit   = (mem_q == match_r) && !(first_r && (removed_r != '0));
  assign ready = (state_r == IDLE);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    removed_nxt   = removed_r;
    dv_nxt        = dv_r;
    first_nxt     = first_r;
    top_nxt       = top_r;
    match_nxt     = match_r;
    status_nxt    = status_r;
    mem_req       = '0;
    mem_req.raddr = MEM_AW'(rd_r);

    case (state_r)
      IDLE: begin
        if (start) begin
          status_nxt  = ST_OK;
          removed_nxt = '0;
          case (cmd_t'(in_cmd))
            CMD_PUSH: begin
              state_nxt = FINISH;
              if (fill_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_AW'(fill_r);
                mem_req.wdata = in_value;
                fill_nxt      = fill_r + CW'(1);
                top_nxt       = in_value;
              end
            end
            CMD_POP: begin
              state_nxt = FINISH;
              if (fill_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                fill_nxt    = fill_r - CW'(1);
                removed_nxt = CW'(1);
                if (fill_r > CW'(1)) begin
                  // fetch the entry that becomes the new top
                  mem_req.raddr = MEM_AW'(fill_r - CW'(2));
                  state_nxt     = POPWT;
                end
              end
            end
            default: begin
              match_nxt = in_value;
              first_nxt = (cmd_t'(in_cmd) == CMD_DEL_FIRST);
              rd_nxt    = '0;
              wr_nxt    = '0;
              dv_nxt    = 1'b0;
              state_nxt = SCAN;
            end
          endcase
        end
      end
      SCAN: begin
        // issue the next read while the previous entry is judged
        if (rd_r < fill_r) begin
          rd_nxt = rd_r + CW'(1);
          dv_nxt = 1'b1;
        end else begin
          dv_nxt = 1'b0;
        end
        if (dv_r) begin
          if (hit) begin
            removed_nxt = removed_r + CW'(1);
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = MEM_AW'(wr_r);
            mem_req.wdata = mem_q;
            wr_nxt        = wr_r + CW'(1);
            top_nxt       = mem_q;
          end
        end else if (rd_r >= fill_r) begin
          fill_nxt  = wr_r;
          state_nxt = FINISH;
        end
      end
      POPWT: begin
        top_nxt   = mem_q;
        state_nxt = FINISH;
      end
      FINISH: begin
        if (out_free) begin
          state_nxt = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_comb begin
    res               = '0;
    res.valid         = (state_r == FINISH);
    res.top_value     = (fill_r == '0) ? 32'sd0 : top_r;
    res.entry_count   = 4'(fill_r);
    res.is_empty      = (fill_r == '0);
    res.is_full       = (fill_r == CW'(DEPTH));
    res.removed_count = 4'(removed_r);
    res.status        = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= IDLE;
      fill_r    <= '0;
      rd_r      <= '0;
      wr_r      <= '0;
      removed_r <= '0;
      dv_r      <= 1'b0;
      first_r   <= 1'b0;
      status_r  <= ST_OK;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      rd_r      <= rd_nxt;
      wr_r      <= wr_nxt;
      removed_r <= removed_nxt;
      dv_r      <= dv_nxt;
      first_r   <= first_nxt;
      status_r  <= status_nxt;
    end
    top_r   <= top_nxt;
    match_r <= match_nxt;
  end

  `SWVD_ASSERT_ALWAYS(a_fill_bound, fill_r <= CW'(DEPTH), "fill level beyond depth")
  `SWVD_ASSERT_ALWAYS(a_wr_behind_rd, (state_r != SCAN) || (wr_r <= rd_r), "compaction overtook scan")
  `SWVD_ASSERT_ALWAYS(a_scan_tally, (state_r != SCAN) || ((wr_r + removed_r) == (rd_r - CW'(dv_r))), "kept plus removed differs from entries judged")
  `SWVD_ASSERT_NEXT(a_push_grows, ready && start && (in_cmd == CMD_PUSH) && (fill_r != CW'(DEPTH)), fill_r == $past(fill_r) + CW'(1), "push did not grow the stack")

endmodule
